// ===== design/object_record_deframer_core_defines.svh =====
// assertion macros shared by the object record deframer
// expects clock and reset in scope at the point of use
`ifndef OBJECT_RECORD_DEFRAMER_CORE_DEFINES_SVH
`define OBJECT_RECORD_DEFRAMER_CORE_DEFINES_SVH

// implication or plain property, checked outside reset
`define ORD_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// condition that must never be seen outside reset
`define ORD_ASSERT_NEVER(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);

`endif

// ===== design/ord_pkg.sv =====
// types and constants for the object record deframer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ord_pkg;

   localparam int OFFSET_BITS_DEFAULT = 32;

   localparam logic [7:0]  TYPE_MODEND = 8'h8A;
   localparam logic [7:0]  TYPE_LIBHDR = 8'hF0;
   localparam logic [7:0]  TYPE_LIBTRL = 8'hF1;
   localparam logic [7:0]  TYPE_BASE_MASK = 8'hFE;
   localparam logic [16:0] HDR_BYTES = 17'd3;

   typedef enum logic [1:0] {
      PH_TYPE,
      PH_LEN_LO,
      PH_LEN_HI,
      PH_BODY
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       file_start;
   } ord_req_type;

   typedef struct packed {
      logic [7:0]  type_byte;
      logic        is_32bit;
      logic        is_library_tail;
      logic [31:0] record_number;
      logic [31:0] record_offset;
      logic [15:0] body_length;
      logic [7:0]  stored_checksum;
      logic [7:0]  computed_checksum;
      logic        checksum_match;
      logic [31:0] padding_total;
   } ord_rsp_type;

endpackage

`default_nettype wire

// ===== design/object_record_deframer_core.sv =====
// Object record deframer: one file byte per beat in, one result per finished record out.
// The result is registered; a stalled output beat holds it back in the skid stage.
// Throughput: one byte per cycle while req_ready is high; after a library header record
// the block pauses while a bit-serial remainder unit finds the page position.
// The input also waits while a second result sits behind a stalled output beat.
// Reset: synchronous, active high, clears control state; file_start restarts framing.
`timescale 1ns / 1ps
`default_nettype none

module object_record_deframer_core #(
   parameter int OFFSET_BITS = ord_pkg::OFFSET_BITS_DEFAULT
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_ready,
   input  wire ord_pkg::ord_req_type req_data,
   output logic                rsp_valid,
   input  wire                 rsp_ready,
   output ord_pkg::ord_rsp_type rsp_data
);
   import ord_pkg::*;

`include "object_record_deframer_core_defines.svh"

   localparam int CntW = $clog2(OFFSET_BITS + 1);

   // framing state
   phase_type              phase_ff, phase_in;
   logic [7:0]             type_ff, type_in;
   logic [15:0]            len_ff, len_in;
   logic [15:0]            left_ff, left_in;
   logic [7:0]             sum_ff, sum_in;
   logic [7:0]             last_ff, last_in;
   logic [31:0]            count_ff, count_in;
   logic [OFFSET_BITS-1:0] pos_ff, pos_in;
   logic [OFFSET_BITS-1:0] start_ff, start_in;
   logic [16:0]            page_size_ff, page_size_in;
   logic [16:0]            page_position_ff, page_position_in;
   logic [16:0]            skip_left_ff, skip_left_in;
   logic [31:0]            pad_ff, pad_in;
   logic                   stopped_ff, stopped_in;

   // page remainder unit
   logic                   div_busy_ff, div_busy_in;
   logic [CntW-1:0]        div_count_ff, div_count_in;
   logic [OFFSET_BITS-1:0] div_shift_ff, div_shift_in;
   logic [16:0]            div_rem_ff, div_rem_in;

   // output register and skid stage
   logic        out_valid_ff, out_valid_in;
   ord_rsp_type out_data_ff, out_data_in;
   logic        skid_valid_ff, skid_valid_in;
   ord_rsp_type skid_data_ff, skid_data_in;

   // state as seen by this beat, after a possible file restart
   phase_type              cur_phase;
   logic [7:0]             cur_type;
   logic [15:0]            cur_len;
   logic [15:0]            cur_left;
   logic [7:0]             cur_sum;
   logic [31:0]            cur_count;
   logic [OFFSET_BITS-1:0] cur_pos;
   logic [OFFSET_BITS-1:0] cur_start;
   logic [16:0]            cur_page_size;
   logic [16:0]            cur_page_position;
   logic [16:0]            cur_skip;
   logic [31:0]            cur_pad;
   logic                   cur_stopped;

   logic        req_fire;
   logic        rsp_pop;
   logic        active;
   logic        hdr_zero;
   logic        finish;
   logic        pp_in_range;
   ord_rsp_type rsp_new;

   assign req_ready = !div_busy_ff && !skid_valid_ff;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;
   assign rsp_pop   = out_valid_ff && rsp_ready;

   assign cur_phase         = req_data.file_start ? PH_TYPE : phase_ff;
   assign cur_type          = req_data.file_start ? '0 : type_ff;
   assign cur_len           = req_data.file_start ? '0 : len_ff;
   assign cur_left          = req_data.file_start ? '0 : left_ff;
   assign cur_sum           = req_data.file_start ? '0 : sum_ff;
   assign cur_count         = req_data.file_start ? '0 : count_ff;
   assign cur_pos           = req_data.file_start ? '0 : pos_ff;
   assign cur_start         = req_data.file_start ? '0 : start_ff;
   assign cur_page_size     = req_data.file_start ? '0 : page_size_ff;
   assign cur_page_position = req_data.file_start ? '0 : page_position_ff;
   assign cur_skip          = req_data.file_start ? '0 : skip_left_ff;
   assign cur_pad           = req_data.file_start ? '0 : pad_ff;
   assign cur_stopped       = req_data.file_start ? 1'b0 : stopped_ff;

   // a beat that frames: not ignored after a trailer, not page padding
   assign active   = req_fire && !cur_stopped && (cur_skip == '0);
   assign hdr_zero = (req_data.data_byte == 8'd0) && (cur_len[7:0] == 8'd0);
   assign finish   = active && (((cur_phase == PH_LEN_HI) && hdr_zero) ||
                                ((cur_phase == PH_BODY) && (cur_left <= 16'd1)));

   // phase next state
   always_comb begin
      phase_in = phase_ff;
      if (active) begin
         unique case (cur_phase)
            PH_TYPE:   phase_in = PH_LEN_LO;
            PH_LEN_LO: phase_in = PH_LEN_HI;
            PH_LEN_HI: phase_in = finish ? PH_TYPE : PH_BODY;
            PH_BODY:   phase_in = finish ? PH_TYPE : PH_BODY;
            default:   phase_in = PH_TYPE;
         endcase
      end else if (req_fire) begin
         phase_in = cur_phase;
      end
   end

   // datapath and page remainder unit
   always_comb begin
      logic [16:0] pp_step;
      logic [15:0] len_v;
      logic [7:0]  last_v;
      logic [7:0]  sum_v;
      logic [7:0]  stored_v;
      logic [7:0]  comp_v;
      logic [7:0]  base_v;
      logic [16:0] skip_v;
      logic [17:0] trial_v;

      type_in          = type_ff;
      len_in           = len_ff;
      left_in          = left_ff;
      sum_in           = sum_ff;
      last_in          = last_ff;
      count_in         = count_ff;
      pos_in           = pos_ff;
      start_in         = start_ff;
      page_size_in     = page_size_ff;
      page_position_in = page_position_ff;
      skip_left_in     = skip_left_ff;
      pad_in           = pad_ff;
      stopped_in       = stopped_ff;
      div_busy_in      = div_busy_ff;
      div_count_in     = div_count_ff;
      div_shift_in     = div_shift_ff;
      div_rem_in       = div_rem_ff;

      pp_step  = cur_page_position;
      len_v    = (cur_phase == PH_LEN_HI) ? {req_data.data_byte, cur_len[7:0]} : cur_len;
      last_v   = (cur_phase == PH_BODY) ? req_data.data_byte : 8'd0;
      sum_v    = cur_sum + req_data.data_byte;
      stored_v = (len_v == 16'd0) ? 8'd0 : last_v;
      comp_v   = 8'd0 - (sum_v - stored_v);
      base_v   = cur_type & TYPE_BASE_MASK;
      skip_v   = '0;
      trial_v  = {div_rem_ff, div_shift_ff[OFFSET_BITS-1]};

      if (cur_page_size != '0) begin
         pp_step = cur_page_position + 17'd1;
         if (pp_step >= cur_page_size) begin
            pp_step = '0;
         end
      end
      if ((base_v == TYPE_MODEND) && (cur_page_size != '0) && (pp_step != '0)) begin
         skip_v = cur_page_size - pp_step;
      end

      rsp_new.type_byte         = cur_type;
      rsp_new.is_32bit          = (cur_type == TYPE_LIBTRL) ? 1'b0 : cur_type[0];
      rsp_new.is_library_tail   = (cur_type == TYPE_LIBTRL);
      rsp_new.record_number     = cur_count + 32'd1;
      rsp_new.record_offset     = 32'(cur_start);
      rsp_new.body_length       = len_v;
      rsp_new.stored_checksum   = stored_v;
      rsp_new.computed_checksum = comp_v;
      rsp_new.checksum_match    = (stored_v == comp_v);
      rsp_new.padding_total     = cur_pad + 32'(skip_v);

      if (div_busy_ff) begin
         // restoring remainder, one dividend bit a cycle
         if (trial_v >= {1'b0, page_size_ff}) begin
            trial_v = trial_v - {1'b0, page_size_ff};
         end
         div_rem_in   = trial_v[16:0];
         div_shift_in = {div_shift_ff[OFFSET_BITS-2:0], 1'b0};
         div_count_in = div_count_ff - CntW'(1);
         if (div_count_ff == CntW'(1)) begin
            div_busy_in      = 1'b0;
            page_position_in = trial_v[16:0];
         end
      end else if (req_fire) begin
         type_in          = cur_type;
         len_in           = cur_len;
         left_in          = cur_left;
         sum_in           = cur_sum;
         count_in         = cur_count;
         pos_in           = cur_pos;
         start_in         = cur_start;
         page_size_in     = cur_page_size;
         page_position_in = cur_page_position;
         skip_left_in     = cur_skip;
         pad_in           = cur_pad;
         stopped_in       = cur_stopped;
         if (req_data.file_start) begin
            last_in = '0;
         end
         if (!cur_stopped) begin
            pos_in           = cur_pos + OFFSET_BITS'(1);
            page_position_in = pp_step;
            if (cur_skip != '0) begin
               skip_left_in = cur_skip - 17'd1;
            end else begin
               unique case (cur_phase)
                  PH_TYPE: begin
                     type_in  = req_data.data_byte;
                     start_in = cur_pos;
                     sum_in   = req_data.data_byte;
                  end
                  PH_LEN_LO: begin
                     len_in = {8'd0, req_data.data_byte};
                     sum_in = sum_v;
                  end
                  PH_LEN_HI: begin
                     len_in  = len_v;
                     sum_in  = sum_v;
                     left_in = len_v;
                     last_in = '0;
                  end
                  PH_BODY: begin
                     sum_in  = sum_v;
                     last_in = req_data.data_byte;
                     if (cur_left != '0) begin
                        left_in = cur_left - 16'd1;
                     end
                  end
                  default: begin
                     sum_in = sum_v;
                  end
               endcase
               if (finish) begin
                  count_in     = cur_count + 32'd1;
                  skip_left_in = skip_v;
                  pad_in       = cur_pad + 32'(skip_v);
                  if (base_v == TYPE_LIBHDR) begin
                     if (cur_type[0]) begin
                        page_size_in     = '0;
                        page_position_in = '0;
                        stopped_in       = 1'b1;
                     end else begin
                        page_size_in = 17'(len_v) + HDR_BYTES;
                        div_busy_in  = 1'b1;
                        div_count_in = CntW'(OFFSET_BITS);
                        div_shift_in = cur_pos + OFFSET_BITS'(1);
                        div_rem_in   = '0;
                     end
                  end
               end
            end
         end
      end
   end

   // output register with skid stage behind it
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || rsp_pop) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = finish;
            out_data_in  = rsp_new;
         end
      end else if (finish) begin
         skid_valid_in = 1'b1;
         skid_data_in  = rsp_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_TYPE;
         type_ff          <= '0;
         len_ff           <= '0;
         left_ff          <= '0;
         sum_ff           <= '0;
         last_ff          <= '0;
         count_ff         <= '0;
         pos_ff           <= '0;
         start_ff         <= '0;
         page_size_ff     <= '0;
         page_position_ff <= '0;
         skip_left_ff     <= '0;
         pad_ff           <= '0;
         stopped_ff       <= 1'b0;
         div_busy_ff      <= 1'b0;
         div_count_ff     <= '0;
         out_valid_ff     <= 1'b0;
         skid_valid_ff    <= 1'b0;
      end else begin
         phase_ff         <= phase_in;
         type_ff          <= type_in;
         len_ff           <= len_in;
         left_ff          <= left_in;
         sum_ff           <= sum_in;
         last_ff          <= last_in;
         count_ff         <= count_in;
         pos_ff           <= pos_in;
         start_ff         <= start_in;
         page_size_ff     <= page_size_in;
         page_position_ff <= page_position_in;
         skip_left_ff     <= skip_left_in;
         pad_ff           <= pad_in;
         stopped_ff       <= stopped_in;
         div_busy_ff      <= div_busy_in;
         div_count_ff     <= div_count_in;
         out_valid_ff     <= out_valid_in;
         skid_valid_ff    <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      div_shift_ff <= div_shift_in;
      div_rem_ff   <= div_rem_in;
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign pp_in_range = (page_position_ff < page_size_ff);

   `ORD_ASSERT_NEVER(a_skid_no_out, skid_valid_ff && !out_valid_ff, "skid without output")
   `ORD_ASSERT(a_pp_range, page_size_ff != '0 && !div_busy_ff |-> pp_in_range, "page position")
   `ORD_ASSERT(a_skip_idle, skip_left_ff != '0 |-> phase_ff == PH_TYPE, "skip inside record")
   `ORD_ASSERT_NEVER(a_stop_page, stopped_ff && (|page_size_ff || div_busy_ff), "after trailer")

endmodule

`default_nettype wire
